@@ rtl/gpsr_pkg.sv @@
// Package for the game pad serial responder.
// Holds phase and command codes, pad IDs and the word and state types.
// No dependencies.
package gpsr_pkg;

  // Transfer phases
  localparam logic [3:0] PH_IDLO = 4'd0;
  localparam logic [3:0] PH_IDHI = 4'd1;
  localparam logic [3:0] PH_SWLO = 4'd2;
  localparam logic [3:0] PH_SWHI = 4'd3;
  localparam logic [3:0] PH_ADC0 = 4'd4;
  localparam logic [3:0] PH_ADC3 = 4'd7;

  // Host commands
  localparam logic [7:0] CMD_POLL     = 8'h42;
  localparam logic [7:0] CMD_CONFIG   = 8'h43;
  localparam logic [7:0] CMD_SET_LED  = 8'h44;
  localparam logic [7:0] CMD_STATUS   = 8'h45;
  localparam logic [7:0] CMD_CONST46  = 8'h46;
  localparam logic [7:0] CMD_CONST47  = 8'h47;
  localparam logic [7:0] CMD_CONST4C  = 8'h4C;
  localparam logic [7:0] CMD_RUMBLE   = 8'h4D;

  // Pad IDs and fixed replies
  localparam logic [15:0] ID_DIGITAL  = 16'h5A41;
  localparam logic [15:0] ID_ANALOG   = 16'h5A73;
  localparam logic [7:0]  ID_CONFIG   = 8'hF3;
  localparam logic [7:0]  RX_HIGHZ    = 8'hFF;

  // One input word
  typedef struct packed {
    logic        mode;
    logic [7:0]  tx_byte;
    logic [15:0] buttons;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
  } item_t;

  // One result word
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        ack;
    logic        error;
    logic [15:0] motor_value;
    logic        led_on;
    logic        in_config;
  } result_t;

  // Protocol state
  typedef struct packed {
    logic        config_mode;
    logic        pending_mode;
    logic [7:0]  cur_cmd;
    logic [3:0]  phase;
    logic        led;
    logic [7:0]  var_idx;
    logic [15:0] rumble;
  } state_t;

endpackage

@@ rtl/game_pad_serial_responder.sv @@
// A word passes through the input register, then the result register, before its result is valid.
// Throughput: one word per cycle while out_ready_i does not stall the result register; gpsr_core is combinational.
// Reset: asynchronous, active low; clears protocol state, controller type and valid flags.
// Top level of the game pad serial responder; depends on gpsr_pkg and gpsr_core.
module game_pad_serial_responder
  import gpsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  tx_byte_i,
  input  logic [15:0] buttons_i,
  input  logic [7:0]  right_x_i,
  input  logic [7:0]  right_y_i,
  input  logic [7:0]  left_x_i,
  input  logic [7:0]  left_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  rx_byte_o,
  output logic        ack_o,
  output logic        error_o,
  output logic [15:0] motor_value_o,
  output logic        led_on_o,
  output logic        in_config_o
);

  logic    ctype_q;
  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t res_q;
  state_t  state_q;
  state_t  state_d;
  result_t res_d;
  logic    advance;

  // Stage moves when the result register is free or being taken
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  // Controller type register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctype_q <= 1'b0;
    end else if (cfg_we_i) begin
      ctype_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= '{mode: mode_i, tx_byte: tx_byte_i, buttons: buttons_i,
                  right_x: right_x_i, right_y: right_y_i,
                  left_x: left_x_i, left_y: left_y_i};
    end
  end

  gpsr_core u_core (
    .item_i   (item_q),
    .ctype_i  (ctype_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Protocol state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) res_q <= res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign rx_byte_o     = res_q.rx_byte;
  assign ack_o         = res_q.ack;
  assign error_o       = res_q.error;
  assign motor_value_o = res_q.motor_value;
  assign led_on_o      = res_q.led_on;
  assign in_config_o   = res_q.in_config;

`ifndef ASSERT_OFF
  // Phase never leaves the legal range
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase <= PH_ADC3)
    else $error("phase out of range");

  // A select word leaves the sequence restarted in normal mode
  a_select_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q && item_q.mode) |=>
      (state_q.phase == PH_IDLO && !state_q.config_mode && res_q.rx_byte == RX_HIGHZ
       && !res_q.ack))
    else $error("select did not restart sequence");

  // A stalled result is held
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(res_q)))
    else $error("stalled result changed");

  // Result flags mirror the protocol state after the word
  a_flags_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q) |=>
      (res_q.in_config == state_q.config_mode && res_q.motor_value == state_q.rumble))
    else $error("result flags disagree with state");
`endif

endmodule

@@ rtl/gpsr_core.sv @@
// Per-word protocol step of the game pad serial responder.
// Combinational: current state and one word in, next state and reply out.
// Depends on gpsr_pkg.
module gpsr_core
  import gpsr_pkg::*;
(
  input  item_t   item_i,
  input  logic    ctype_i,
  input  state_t  state_i,
  output state_t  state_o,
  output result_t result_o
);

  // Reply of a configuration command in phases two to seven
  function automatic logic [7:0] cfg_reply(input logic [2:0] k, input logic [7:0] c,
                                           input logic [7:0] ii, input logic led,
                                           input item_t it);
    logic [7:0] r;
    r = 8'h00;
    unique case (c)
      CMD_POLL: begin
        unique case (k)
          3'd0:    r = it.buttons[7:0];
          3'd1:    r = it.buttons[15:8];
          3'd2:    r = it.right_x;
          3'd3:    r = it.right_y;
          3'd4:    r = it.left_x;
          default: r = it.left_y;
        endcase
      end
      CMD_STATUS: begin
        unique case (k)
          3'd0:    r = 8'h01;
          3'd1:    r = 8'h02;
          3'd2:    r = {7'd0, led};
          3'd3:    r = 8'h02;
          3'd4:    r = 8'h01;
          default: r = 8'h00;
        endcase
      end
      CMD_CONST46: begin
        if (ii == 8'd0) begin
          unique case (k)
            3'd2:    r = 8'h01;
            3'd3:    r = 8'h02;
            3'd5:    r = 8'h0A;
            default: r = 8'h00;
          endcase
        end else if (ii == 8'd1) begin
          unique case (k)
            3'd2, 3'd3, 3'd4: r = 8'h01;
            3'd5:             r = 8'h14;
            default:          r = 8'h00;
          endcase
        end
      end
      CMD_CONST47: begin
        if (k == 3'd2) r = 8'h02;
        else if (k == 3'd4) r = 8'h01;
      end
      CMD_CONST4C: begin
        if (k == 3'd3) begin
          if (ii == 8'd0) r = 8'h04;
          else if (ii == 8'd1) r = 8'h07;
        end
      end
      CMD_RUMBLE: r = 8'hFF;
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

  logic [15:0] pad_id;
  logic [3:0]  ph;
  logic [3:0]  ph_inc;
  logic [2:0]  k;
  logic        cfg_known;
  logic [7:0]  rx;
  logic        ack;
  logic        err;
  state_t      nxt;

  assign pad_id = ctype_i ? ID_ANALOG : ID_DIGITAL;
  // Stray phases act as id low
  assign ph     = (state_i.phase > PH_ADC3) ? PH_IDLO : state_i.phase;
  assign ph_inc = ph + 4'd1;
  assign k      = 3'(ph - PH_SWLO);
  assign cfg_known = (item_i.tx_byte >= CMD_POLL && item_i.tx_byte <= CMD_CONST47) ||
                     item_i.tx_byte == CMD_CONST4C || item_i.tx_byte == CMD_RUMBLE;

  // Next state and reply
  always_comb begin
    nxt = state_i;
    rx  = 8'h00;
    ack = 1'b1;
    err = 1'b0;
    if (item_i.mode) begin
      // select: restart the sequence in normal mode
      nxt.config_mode  = 1'b0;
      nxt.pending_mode = 1'b0;
      nxt.cur_cmd      = 8'h00;
      nxt.phase        = PH_IDLO;
      rx  = RX_HIGHZ;
      ack = 1'b0;
    end else if (ph == PH_IDLO) begin
      nxt.cur_cmd = item_i.tx_byte;
      nxt.phase   = PH_IDLO;
      if (state_i.config_mode) begin
        if (cfg_known) begin
          rx = ID_CONFIG;
          nxt.phase = PH_IDHI;
        end else begin
          rx = RX_HIGHZ; ack = 1'b0; err = 1'b1;
        end
      end else if (item_i.tx_byte == CMD_POLL || (item_i.tx_byte == CMD_CONFIG && ctype_i)) begin
        rx = pad_id[7:0];
        nxt.phase = PH_IDHI;
      end else if (item_i.tx_byte == CMD_CONFIG) begin
        rx = RX_HIGHZ; ack = 1'b0;
      end else begin
        rx = RX_HIGHZ; ack = 1'b0; err = 1'b1;
      end
    end else if (ph == PH_IDHI) begin
      rx = pad_id[15:8];
      nxt.phase = PH_SWLO;
    end else if (!state_i.config_mode) begin
      // normal mode data bytes
      if (ph == PH_SWLO) begin
        if (state_i.cur_cmd == CMD_POLL) begin
          nxt.rumble[7:0] = item_i.tx_byte;
        end else if (state_i.cur_cmd == CMD_CONFIG && ctype_i) begin
          if (item_i.tx_byte <= 8'd1) nxt.pending_mode = item_i.tx_byte[0];
          else err = 1'b1;
        end
        rx = item_i.buttons[7:0];
        nxt.phase = PH_SWHI;
      end else if (ph == PH_SWHI) begin
        if (state_i.cur_cmd == CMD_POLL) nxt.rumble[15:8] = item_i.tx_byte;
        rx = item_i.buttons[15:8];
        if (ctype_i) begin
          nxt.phase = PH_ADC0;
        end else begin
          nxt.phase = PH_IDLO; nxt.config_mode = state_i.pending_mode; ack = 1'b0;
        end
      end else begin
        unique case (ph[1:0])
          2'd0:    rx = item_i.right_x;
          2'd1:    rx = item_i.right_y;
          2'd2:    rx = item_i.left_x;
          default: rx = item_i.left_y;
        endcase
        if (ph == PH_ADC3) begin
          nxt.phase = PH_IDLO; nxt.config_mode = state_i.pending_mode; ack = 1'b0;
        end else begin
          nxt.phase = ph_inc;
        end
      end
    end else begin
      // configuration mode data bytes; parameters latch on the first one
      if (ph == PH_SWLO) begin
        if (state_i.cur_cmd == CMD_CONFIG) begin
          if (item_i.tx_byte <= 8'd1) nxt.pending_mode = item_i.tx_byte[0];
          else err = 1'b1;
        end else if (state_i.cur_cmd == CMD_SET_LED) begin
          if (item_i.tx_byte <= 8'd1) nxt.led = item_i.tx_byte[0];
        end else if (state_i.cur_cmd == CMD_CONST46 || state_i.cur_cmd == CMD_CONST4C) begin
          nxt.var_idx = item_i.tx_byte;
        end
      end
      rx = cfg_reply(k, state_i.cur_cmd, nxt.var_idx, nxt.led, item_i);
      if (ph == PH_ADC3) begin
        nxt.phase = PH_IDLO; nxt.config_mode = nxt.pending_mode; ack = 1'b0;
      end else begin
        nxt.phase = ph_inc;
      end
    end
  end

  assign state_o = nxt;
  assign result_o = '{rx_byte:     rx,
                      ack:         ack,
                      error:       err,
                      motor_value: nxt.rumble,
                      led_on:      nxt.led,
                      in_config:   nxt.config_mode};

endmodule
